// File: hdl/ffha_pkg.sv
package ffha_pkg;

  // Fixed field widths of the request and result items
  localparam int SZ_W   = 13;
  localparam int ADDR_W = 13;

  // One block header as kept in the header memory
  typedef struct packed {
    logic            is_free;
    logic            is_end;
    logic [SZ_W-1:0] size;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_NEED,
    S_HDR,
    S_BND,
    S_FIT,
    S_SPL,
    S_USE,
    S_PAY,
    S_FCHK,
    S_FRNG,
    S_FHDR,
    S_FBND,
    S_FNX,
    S_FMRG,
    S_OUT
  } state_t;

  // Memory write request, steered by the sequencer
  typedef struct packed {
    logic en;
    hdr_t data;
  } mem_wr_t;

endpackage

// File: hdl/ffha_alu.sv
module ffha_alu #(
  parameter int W = 16
) (
  input  ffha_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      res,
  output logic              borrow
);
  import ffha_pkg::*;

  // Operands stay below half the range, so the top bit flags a borrow
  always_comb begin
    unique case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      default: res = a + b;
    endcase
    borrow = (op == ALU_SUB) && res[W-1];
  end

endmodule

// File: hdl/ffha_mem.sv
module ffha_mem #(
  parameter int DEPTH = 4104,
  parameter int AW    = 13
) (
  input  logic             clk,
  input  ffha_pkg::mem_wr_t wr,
  input  logic [AW-1:0]    wr_addr,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output ffha_pkg::hdr_t   rd_data
);
  import ffha_pkg::*;

  hdr_t mem [DEPTH];
  hdr_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/first_fit_heap_allocator.sv
// First-fit heap allocator with block headers kept in an on-chip header memory.
// Input channel (in_valid / in_stall): in_mode 0 asks for in_request_size
// payload bytes, in_mode 1 frees the block whose payload offset is
// in_free_address. Result channel (out_valid / out_stall): out_address is the
// payload offset of a granted block (0 on failure and on every free), out_ok
// flags success. One result per transfer on the input side.
// An allocation walks the block chain from offset 0 through one header read
// per block: a start step; header, bound and fit or advance steps per block;
// split steps writing the leftover and granted headers; a result-load step.
// A free checks the address, marks the header free, may merge the next block.
// The single read port and shared adder/subtractor set this order; one item is in
// flight at a time, and the next is taken the cycle after the result loads.
// After reset the block sweeps all HEAP_BYTES + HEADER_BYTES entries of the
// header memory (4104 at the defaults), one entry a cycle, leaving one free
// end block of HEAP_BYTES at offset 0; in_stall stays high meanwhile.
// The result register holds a finished result while out_stall is high; the
// block still takes the next item, and only that item's final step waits.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [ffha_pkg::SZ_W-1:0]   in_request_size,
  input  logic [ffha_pkg::ADDR_W-1:0] in_free_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ffha_pkg::ADDR_W-1:0] out_address,
  output logic                        out_ok
);
  import ffha_pkg::*;

  localparam int DEPTH = HEAP_BYTES + HEADER_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = (AW > SZ_W) ? AW : SZ_W;
  // Room for a payload offset plus a block size, with a spare borrow bit
  localparam int W     = MW + 3;

  localparam logic [W-1:0]    DEPTH_W = W'(DEPTH);
  localparam logic [W-1:0]    HDR_B_W = W'(HEADER_BYTES);
  localparam logic [AW-1:0]   LAST_A  = AW'(DEPTH - 1);
  localparam logic [SZ_W-1:0] INIT_SZ = SZ_W'(HEAP_BYTES);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [SZ_W-1:0]     req_r, req_nxt;
  logic [W-1:0]        pos_r, pos_nxt;
  logic [W-1:0]        pay_r, pay_nxt;
  logic [W-1:0]        nxt_r, nxt_nxt;
  logic [W-1:0]        need_r, need_nxt;
  hdr_t                hdr_r, hdr_nxt;
  logic                nend_r, nend_nxt;
  logic                full_r, full_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_address_r, out_address_nxt;
  logic                out_ok_r, out_ok_nxt;

  alu_op_t             alu_op;
  logic [W-1:0]        alu_a, alu_b, alu_res;
  logic                alu_borrow;

  mem_wr_t             mem_wr;
  logic [AW-1:0]       wr_addr;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  hdr_t                rd_data;

  ffha_alu #(.W(W)) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  ffha_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_address = out_address_r;
  assign out_ok      = out_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    pos_r         <= pos_nxt;
    pay_r         <= pay_nxt;
    nxt_r         <= nxt_nxt;
    need_r        <= need_nxt;
    hdr_r         <= hdr_nxt;
    nend_r        <= nend_nxt;
    full_r        <= full_nxt;
    res_addr_r    <= res_addr_nxt;
    res_ok_r      <= res_ok_nxt;
    out_address_r <= out_address_nxt;
    out_ok_r      <= out_ok_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    req_nxt         = req_r;
    pos_nxt         = pos_r;
    pay_nxt         = pay_r;
    nxt_nxt         = nxt_r;
    need_nxt        = need_r;
    hdr_nxt         = hdr_r;
    nend_nxt        = nend_r;
    full_nxt        = full_r;
    res_addr_nxt    = res_addr_r;
    res_ok_nxt      = res_ok_r;
    out_valid_nxt   = out_valid_r;
    out_address_nxt = out_address_r;
    out_ok_nxt      = out_ok_r;

    alu_op          = ALU_ADD;
    alu_a           = '0;
    alu_b           = '0;
    mem_wr          = '0;
    wr_addr         = pos_r[AW-1:0];
    rd_en           = 1'b0;
    rd_addr         = pos_r[AW-1:0];

    // Drop the result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // Sweep the header memory after reset
      S_CLR: begin
        mem_wr.en = 1'b1;
        wr_addr   = clr_r;
        if (clr_r == '0) begin
          mem_wr.data = '{is_free: 1'b1, is_end: 1'b1, size: INIT_SZ};
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_A) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_request_size;
          pay_nxt   = W'(in_free_address);
          state_nxt = in_mode ? S_FCHK : S_NEED;
        end
      end

      // Allocation: compute request plus one header, start at offset 0
      S_NEED: begin
        alu_op    = ALU_ADD;
        alu_a     = W'(req_r);
        alu_b     = HDR_B_W;
        need_nxt  = alu_res;
        pos_nxt   = '0;
        pay_nxt   = HDR_B_W;
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = S_HDR;
      end

      // Header in hand: offset of the following block
      S_HDR: begin
        hdr_nxt   = rd_data;
        alu_op    = ALU_ADD;
        alu_a     = pay_r;
        alu_b     = W'(rd_data.size);
        nxt_nxt   = alu_res;
        state_nxt = S_BND;
      end

      // A block reaching past the store ends the walk
      S_BND: begin
        alu_op   = ALU_SUB;
        alu_a    = DEPTH_W;
        alu_b    = nxt_r;
        full_nxt = (alu_res == '0);
        if (alu_borrow) begin
          res_addr_nxt = '0;
          res_ok_nxt   = 1'b0;
          state_nxt    = S_OUT;
        end else if (hdr_r.is_free) begin
          state_nxt = S_FIT;
        end else if (hdr_r.is_end) begin
          res_addr_nxt = '0;
          res_ok_nxt   = 1'b0;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_PAY;
        end
      end

      // Size check; the difference is the leftover size
      S_FIT: begin
        alu_op = ALU_SUB;
        alu_a  = W'(hdr_r.size);
        alu_b  = need_r;
        if (!alu_borrow) begin
          nxt_nxt   = alu_res;
          state_nxt = S_SPL;
        end else if (hdr_r.is_end) begin
          res_addr_nxt = '0;
          res_ok_nxt   = 1'b0;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_PAY;
        end
      end

      // Write the leftover header behind the granted block
      S_SPL: begin
        alu_op      = ALU_ADD;
        alu_a       = pos_r;
        alu_b       = need_r;
        mem_wr.en   = 1'b1;
        wr_addr     = alu_res[AW-1:0];
        mem_wr.data = '{is_free: hdr_r.is_free, is_end: hdr_r.is_end,
                        size: nxt_r[SZ_W-1:0]};
        state_nxt   = S_USE;
      end

      S_USE: begin
        mem_wr.en    = 1'b1;
        wr_addr      = pos_r[AW-1:0];
        mem_wr.data  = '{is_free: 1'b0, is_end: 1'b0, size: req_r};
        res_addr_nxt = pay_r[ADDR_W-1:0];
        res_ok_nxt   = 1'b1;
        state_nxt    = S_OUT;
      end

      // Advance to the following header
      S_PAY: begin
        if (full_r) begin
          res_addr_nxt = '0;
          res_ok_nxt   = 1'b0;
          state_nxt    = S_OUT;
        end else begin
          alu_op    = ALU_ADD;
          alu_a     = nxt_r;
          alu_b     = HDR_B_W;
          pay_nxt   = alu_res;
          pos_nxt   = nxt_r;
          rd_en     = 1'b1;
          rd_addr   = nxt_r[AW-1:0];
          state_nxt = S_HDR;
        end
      end

      // Free: header offset below the payload
      S_FCHK: begin
        alu_op  = ALU_SUB;
        alu_a   = pay_r;
        alu_b   = HDR_B_W;
        pos_nxt = alu_res;
        if (alu_borrow) begin
          res_addr_nxt = '0;
          res_ok_nxt   = 1'b0;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_FRNG;
        end
      end

      S_FRNG: begin
        alu_op = ALU_SUB;
        alu_a  = pos_r;
        alu_b  = DEPTH_W;
        if (!alu_borrow) begin
          res_addr_nxt = '0;
          res_ok_nxt   = 1'b0;
          state_nxt    = S_OUT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = pos_r[AW-1:0];
          state_nxt = S_FHDR;
        end
      end

      // Mark free, then look at the following block unless this is the end
      S_FHDR: begin
        hdr_nxt      = rd_data;
        mem_wr.en    = 1'b1;
        wr_addr      = pos_r[AW-1:0];
        mem_wr.data  = '{is_free: 1'b1, is_end: rd_data.is_end, size: rd_data.size};
        alu_op       = ALU_ADD;
        alu_a        = pay_r;
        alu_b        = W'(rd_data.size);
        nxt_nxt      = alu_res;
        res_addr_nxt = '0;
        res_ok_nxt   = 1'b1;
        state_nxt    = rd_data.is_end ? S_OUT : S_FBND;
      end

      S_FBND: begin
        alu_op = ALU_SUB;
        alu_a  = nxt_r;
        alu_b  = DEPTH_W;
        if (!alu_borrow) begin
          state_nxt = S_OUT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = nxt_r[AW-1:0];
          state_nxt = S_FNX;
        end
      end

      S_FNX: begin
        if (!rd_data.is_free) begin
          state_nxt = S_OUT;
        end else begin
          alu_op    = ALU_ADD;
          alu_a     = W'(hdr_r.size);
          alu_b     = W'(rd_data.size);
          nxt_nxt   = alu_res;
          nend_nxt  = rd_data.is_end;
          state_nxt = S_FMRG;
        end
      end

      // Merge only if the combined size fits the size field
      S_FMRG: begin
        alu_op = ALU_ADD;
        alu_a  = nxt_r;
        alu_b  = HDR_B_W;
        if (alu_res[W-1:SZ_W] == '0) begin
          mem_wr.en   = 1'b1;
          wr_addr     = pos_r[AW-1:0];
          mem_wr.data = '{is_free: 1'b1, is_end: nend_r, size: alu_res[SZ_W-1:0]};
        end
        state_nxt = S_OUT;
      end

      // Hold the result until the output register frees up
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_address_nxt = res_addr_r;
          out_ok_nxt      = res_ok_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A new result appears only out of the result-loading step
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the result-loading step");

  // No transfer is taken while the header memory is being swept
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall)
    else $error("input taken during the clearing sweep");

  // Header writes stay inside the store
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.en |-> (W'(wr_addr) < DEPTH_W))
    else $error("header write beyond the store");

  // A failed or refused request never reports a nonzero address
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_address_r == '0))
    else $error("failure reported with a nonzero address");

endmodule

// File: dv/heap_grant_checker.sv
package heap_tb_pkg;

  typedef enum logic [0:0] {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_mode_t;

endpackage

module heap_grant_checker #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_mode,
  input  logic [ffha_pkg::SZ_W-1:0]   in_request_size,
  input  logic [ffha_pkg::ADDR_W-1:0] in_free_address,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [ffha_pkg::ADDR_W-1:0] out_address,
  input  logic                        out_ok,
  output int                          error_total,
  output int                          awaiting
);
  import ffha_pkg::*;
  import heap_tb_pkg::*;

  localparam int DEPTH    = HEAP_BYTES + HEADER_BYTES;
  localparam int SIZE_MAX = 2**SZ_W - 1;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              ok;
  } grant_t;

  hdr_t   heap_hdr [DEPTH];
  grant_t expected_grants [$];

  // Walk the chain from offset 0 and split the first free block that holds
  // the request plus a header; an exact fit is refused.
  function automatic grant_t carve_first_fit(input int req);
    int     pos;
    int     need;
    int     nxt;
    int     split;
    grant_t g;
    g    = '0;
    pos  = 0;
    need = req + HEADER_BYTES;
    while (pos < DEPTH) begin
      nxt = pos + HEADER_BYTES + int'(heap_hdr[pos].size);
      if (nxt > DEPTH) break;
      if (heap_hdr[pos].is_free && int'(heap_hdr[pos].size) >= need) begin
        split = pos + need;
        heap_hdr[split]      = heap_hdr[pos];
        heap_hdr[split].size = SZ_W'(int'(heap_hdr[pos].size) - need);
        heap_hdr[pos]        = '{is_free: 1'b0, is_end: 1'b0, size: SZ_W'(req)};
        g.address = ADDR_W'(pos + HEADER_BYTES);
        g.ok      = 1'b1;
        return g;
      end
      if (heap_hdr[pos].is_end) break;
      pos = nxt;
    end
    return g;
  endfunction

  // Mark the block free and fold in the following block if that one is free and the merged size fits.
  function automatic grant_t release_block(input int addr);
    int     pos;
    int     nxt;
    int     merged;
    grant_t g;
    g = '0;
    if (addr < HEADER_BYTES || addr - HEADER_BYTES >= DEPTH) return g;
    pos = addr - HEADER_BYTES;
    heap_hdr[pos].is_free = 1'b1;
    g.ok = 1'b1;
    if (heap_hdr[pos].is_end) return g;
    nxt = pos + HEADER_BYTES + int'(heap_hdr[pos].size);
    if (nxt >= DEPTH) return g;
    if (heap_hdr[nxt].is_free) begin
      merged = int'(heap_hdr[pos].size) + int'(heap_hdr[nxt].size) + HEADER_BYTES;
      if (merged <= SIZE_MAX) begin
        heap_hdr[pos].is_free = heap_hdr[nxt].is_free;
        heap_hdr[pos].is_end  = heap_hdr[nxt].is_end;
        heap_hdr[pos].size    = SZ_W'(merged);
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      foreach (heap_hdr[i]) heap_hdr[i] = '0;
      heap_hdr[0] = '{is_free: 1'b1, is_end: 1'b1, size: SZ_W'(HEAP_BYTES)};
      expected_grants.delete();
      error_total = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          $error("result transfer with nothing pending: address %0d ok %0b",
                 out_address, out_ok);
          error_total++;
        end else begin
          want = expected_grants.pop_front();
          if (out_address !== want.address) begin
            $error("address: expected %0d, actual %0d", want.address, out_address);
            error_total++;
          end
          if (out_ok !== want.ok) begin
            $error("ok: expected %0b, actual %0b", want.ok, out_ok);
            error_total++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_mode == REQ_FREE) expected_grants.push_back(release_block(int'(in_free_address)));
        else expected_grants.push_back(carve_first_fit(int'(in_request_size)));
      end
    end
    awaiting = expected_grants.size();
  end

endmodule

// File: dv/first_fit_heap_allocator_tb.sv
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;
  import heap_tb_pkg::*;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 8;
  // Cycles with no transfer on either channel before the run is declared hung.
  // Covers the header clearing sweep after reset, the long receiver hold and
  // the longest chain walk with plenty of margin.
  localparam int STALL_LIMIT  = 20000;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 280;
  localparam int DRAIN_CYCLES = 40;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_mode = REQ_ALLOC;
  logic [SZ_W-1:0]   in_request_size = '0;
  logic [ADDR_W-1:0] in_free_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] out_address;
  logic              out_ok;

  int error_total;
  int awaiting;

  // Idle percentages for each side, changed per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long receiver hold: the stimulus bumps the request count, the receiver
  // process serves it and counts the hold down on its own.
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  int quiet_cycles = 0;

  // Payload offsets handed out by the block, used to aim frees at live blocks.
  logic [ADDR_W-1:0] granted [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_fit_heap_allocator #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_request_size(in_request_size),
    .in_free_address(in_free_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_address    (out_address),
    .out_ok         (out_ok)
  );

  heap_grant_checker #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_request_size(in_request_size),
    .in_free_address(in_free_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_address    (out_address),
    .out_ok         (out_ok),
    .error_total    (error_total),
    .awaiting       (awaiting)
  );

  // Receiver: serve a pending long hold first, otherwise stall at random.
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Collect granted offsets as result transfers complete.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_ok && out_address != '0)
      granted.push_back(out_address);
  end

  // Watchdog: count cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer one item and hold it until the transfer. Start and end on a falling
  // edge; scribble on the payload while idling since it is ignored then.
  task automatic offer(input req_mode_t m, input int size, input int addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid        <= 1'b0;
      in_mode         <= 1'($urandom);
      in_request_size <= SZ_W'($urandom);
      in_free_address <= ADDR_W'($urandom);
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= m;
    in_request_size <= SZ_W'(size);
    in_free_address <= ADDR_W'(addr);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly frees of live blocks and allocations of modest size, with some
  // stray frees and a few very large requests to push the heap to failure.
  task automatic random_item();
    int                roll;
    int                pick;
    int                size;
    logic [ADDR_W-1:0] addr;
    roll = $urandom_range(99);
    if (roll < 45 && granted.size() > 0) begin
      pick = $urandom_range(granted.size() - 1);
      addr = granted[pick];
      granted.delete(pick);
      offer(REQ_FREE, $urandom_range(HEAP_BYTES), int'(addr));
    end else if (roll < 50) begin
      offer(REQ_FREE, $urandom_range(HEAP_BYTES),
            $urandom_range(HEAP_BYTES + HEADER_BYTES - 1));
    end else begin
      pick = $urandom_range(99);
      if (pick < 50)      size = $urandom_range(64);
      else if (pick < 80) size = $urandom_range(400, 65);
      else if (pick < 95) size = $urandom_range(1500, 401);
      else begin
        case ($urandom_range(4))
          0:       size = 0;
          1:       size = HEAP_BYTES;
          2:       size = HEAP_BYTES - HEADER_BYTES;
          3:       size = HEAP_BYTES - HEADER_BYTES - 1;
          default: size = $urandom_range(HEAP_BYTES, 1501);
        endcase
      end
      offer(REQ_ALLOC, size, $urandom_range(HEAP_BYTES + HEADER_BYTES - 1));
    end
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with the first idle mix already active.
    send_idle_pct = 35;
    recv_idle_pct = 50;
    offer(REQ_ALLOC, HEAP_BYTES, 0);                 // too big: exact fit refused
    offer(REQ_ALLOC, HEAP_BYTES - HEADER_BYTES, 0);  // leaves a zero-size remainder
    offer(REQ_ALLOC, 0, 0);                          // only the empty tail left
    offer(REQ_FREE, 0, HEADER_BYTES);                // merge with the empty tail
    offer(REQ_ALLOC, 0, 0);
    offer(REQ_ALLOC, 1, 0);
    offer(REQ_ALLOC, 100, 0);
    offer(REQ_FREE, 0, 0);                           // below the first payload
    offer(REQ_FREE, 0, HEADER_BYTES - 1);
    offer(REQ_FREE, 0, 16);                          // neighbor in use: no merge
    offer(REQ_ALLOC, 1, 0);
    offer(REQ_FREE, 0, 142);                         // the end block itself
    offer(REQ_FREE, 0, 133);                         // merge with the free end block
    offer(REQ_FREE, 0, HEAP_BYTES + HEADER_BYTES - 1);  // stray free at the top
    offer(REQ_FREE, 0, HEAP_BYTES);                  // stray free
    offer(REQ_FREE, 0, 8);                           // merge forward
    offer(REQ_ALLOC, HEAP_BYTES - HEADER_BYTES - 1, 0);
    offer(REQ_ALLOC, HEAP_BYTES, 0);

    // Phase one: sender idles less than the receiver. Partway through, hold
    // the receiver off for a long stretch while items keep coming.
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == 100) hold_requests++;
      random_item();
    end

    // Pause the sender until the block has answered everything.
    drain();

    // Phase two: roles swapped.
    send_idle_pct = 50;
    recv_idle_pct = 35;
    for (int i = 0; i < PHASE_ITEMS; i++) random_item();

    // Phase three: back to back on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < PHASE_ITEMS; i++) random_item();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_total == 0 && awaiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ffha_pkg.sv
hdl/ffha_alu.sv
hdl/ffha_mem.sv
hdl/first_fit_heap_allocator.sv
dv/heap_grant_checker.sv
dv/first_fit_heap_allocator_tb.sv
